### rtl/core/gmsp_pkg.sv
// gmsp_pkg: shared constants and types for the grid min-step path block
// no dependencies; imported by every module under rtl/core
package gmsp_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int SIZE_W = 7;                    // width of row_count / col_count
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int DIST_W = 8;
  localparam int STEP_W = 7;
  localparam int ADDR_W = 3;

  localparam logic [DIST_W-1:0] DIST_UNREACH = '1;
  localparam logic [DIST_W-1:0] DIST_SAT     = DIST_UNREACH - 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // one accepted cell and where it sits in the grid
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             first_col;
    logic             last;
    logic             blocked;
  } cell_t;

  // grid extent, already clamped, minus one
  typedef struct packed {
    logic [ROW_W-1:0] rows_m1;
    logic [COL_W-1:0] cols_m1;
    logic             restart;
  } grid_cfg_t;

  // stage-1 status seen by the top level
  typedef struct packed {
    logic valid;
    logic last;
  } dp_status_t;

endpackage

### rtl/core/grid_min_step_path.sv
// grid_min_step_path: top level, fewest-move monotone path over a streamed grid
// depends on gmsp_pkg, gmsp_cfg, gmsp_seq, gmsp_dp
//
//   channel   signals                         moves
//   cell      cell_valid / cell_stall         blocked, one cell per request
//   result    result_valid / result_stall     reachable, step_count after last cell
//   config    apb psel/penable/pwrite/paddr   row_count @0, col_count @4
//
// one cell per cycle sustained while cell_stall is low; the row memory read is issued as a
// cell is accepted and the update stage works on it the next cycle, and result_valid is
// registered once the update stage moves past the last cell of a grid.
// the row memory has one read port and one write port: one read and one write per cycle.
// reset (rst, synchronous) returns to row 0 column 0; any config write does the same.
// cell_stall rises only while a finished result is held and the next grid end arrives.
module grid_min_step_path (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          cell_valid,
  output logic                          cell_stall,
  input  logic                          blocked,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          reachable,
  output logic [gmsp_pkg::STEP_W-1:0]   step_count
);
  import gmsp_pkg::*;

  grid_cfg_t         grid_cfg;
  cell_t             cell_info;
  dp_status_t        dp_status;
  logic              accept;
  logic              advance;
  logic              dp_reachable;
  logic [STEP_W-1:0] dp_step_count;

  gmsp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .grid_cfg (grid_cfg)
  );

  gmsp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .grid_cfg  (grid_cfg),
    .accept    (accept),
    .blocked   (blocked),
    .cell_info (cell_info)
  );

  gmsp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cell_info  (cell_info),
    .advance    (advance),
    .status     (dp_status),
    .reachable  (dp_reachable),
    .step_count (dp_step_count)
  );

  // update stage only waits when it holds a grid end and the result slot is full
  assign advance    = dp_status.valid && !(dp_status.last && result_valid && result_stall);
  assign cell_stall = dp_status.valid && !advance;
  assign accept     = cell_valid && !cell_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && dp_status.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dp_status.last) begin
      reachable  <= dp_reachable;
      step_count <= dp_step_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    cell_stall |-> (result_valid && result_stall && dp_status.last))
    else $error("cell stall without a held result");

  a_unreachable_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !reachable) |-> (step_count == '0))
    else $error("unreachable result with nonzero step count");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (step_count <= STEP_W'(126)))
    else $error("step count beyond grid diagonal bound");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    (advance && dp_status.last) |=> result_valid)
    else $error("grid end did not produce a result");
`endif

endmodule

### rtl/core/gmsp_cfg.sv
// gmsp_cfg: apb register file for row_count and col_count, with size clamping
// depends on gmsp_pkg
module gmsp_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gmsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output gmsp_pkg::grid_cfg_t          grid_cfg
);
  import gmsp_pkg::*;

  logic [SIZE_W-1:0] row_count;
  logic [SIZE_W-1:0] col_count;
  logic              wr_en;
  logic [SIZE_W-1:0] rows_clamped;
  logic [SIZE_W-1:0] cols_clamped;
  logic [SIZE_W-1:0] rows_m1_wide;
  logic [SIZE_W-1:0] cols_m1_wide;

  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= SIZE_W'(9);
      col_count <= SIZE_W'(5);
    end else if (wr_en) begin
      case (paddr[2])
        REG_ROW_COUNT: row_count <= pwdata[SIZE_W-1:0];
        REG_COL_COUNT: col_count <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_COUNT: prdata = {{(32-SIZE_W){1'b0}}, row_count};
      REG_COL_COUNT: prdata = {{(32-SIZE_W){1'b0}}, col_count};
      default:       prdata = '0;
    endcase
  end

  // zero counts as one, anything above the maximum as the maximum
  always_comb begin
    if (row_count == '0)                    rows_clamped = SIZE_W'(1);
    else if (row_count > SIZE_W'(MAX_ROWS)) rows_clamped = SIZE_W'(MAX_ROWS);
    else                                    rows_clamped = row_count;
    if (col_count == '0)                    cols_clamped = SIZE_W'(1);
    else if (col_count > SIZE_W'(MAX_COLS)) cols_clamped = SIZE_W'(MAX_COLS);
    else                                    cols_clamped = col_count;
  end

  assign rows_m1_wide = rows_clamped - SIZE_W'(1);
  assign cols_m1_wide = cols_clamped - SIZE_W'(1);

  assign grid_cfg.rows_m1 = rows_m1_wide[ROW_W-1:0];
  assign grid_cfg.cols_m1 = cols_m1_wide[COL_W-1:0];
  assign grid_cfg.restart = wr_en;

endmodule

### rtl/core/gmsp_seq.sv
// gmsp_seq: row/column position counters for the incoming cell stream
// depends on gmsp_pkg
module gmsp_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  gmsp_pkg::grid_cfg_t  grid_cfg,
  input  logic                 accept,
  input  logic                 blocked,
  output gmsp_pkg::cell_t      cell_info
);
  import gmsp_pkg::*;

  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic             row_end;
  logic             grid_end;

  assign row_end  = (cur_col == grid_cfg.cols_m1);
  assign grid_end = row_end && (cur_row == grid_cfg.rows_m1);

  always_ff @(posedge clk) begin
    if (rst || grid_cfg.restart) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (accept) begin
      if (grid_end) begin
        cur_row <= '0;
        cur_col <= '0;
      end else if (row_end) begin
        cur_row <= cur_row + 1'b1;
        cur_col <= '0;
      end else begin
        cur_col <= cur_col + 1'b1;
      end
    end
  end

  assign cell_info.col       = cur_col;
  assign cell_info.first_row = (cur_row == '0);
  assign cell_info.first_col = (cur_col == '0);
  assign cell_info.last      = grid_end;
  assign cell_info.blocked   = blocked;

endmodule

### rtl/core/gmsp_dp.sv
// gmsp_dp: row distance memory and the per-cell min-plus-one update
// depends on gmsp_pkg; read registered at accept, then update and write-back in stage 1
module gmsp_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  gmsp_pkg::cell_t             cell_info,
  input  logic                        advance,
  output gmsp_pkg::dp_status_t        status,
  output logic                        reachable,
  output logic [gmsp_pkg::STEP_W-1:0] step_count
);
  import gmsp_pkg::*;

  logic [DIST_W-1:0] row_mem [MAX_COLS];
  logic [DIST_W-1:0] rd_data;
  logic              fwd_hit;
  logic [DIST_W-1:0] fwd_data;

  logic              s1_valid;
  cell_t             s1;
  logic [DIST_W-1:0] left_dist;
  logic [DIST_W-1:0] diag_dist;

  logic [DIST_W-1:0] up;
  logic [DIST_W-1:0] best;
  logic [DIST_W-1:0] arrive;
  logic [DIST_W-1:0] eff;
  logic              wr_en;

  assign wr_en = advance && !s1.last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[s1.col] <= eff;
    end
    if (accept) begin
      rd_data  <= row_mem[cell_info.col];
      // single-column grid: the cell above is being written this same edge
      fwd_hit  <= wr_en && (s1.col == cell_info.col);
      fwd_data <= eff;
      s1       <= cell_info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      left_dist <= DIST_UNREACH;
      diag_dist <= DIST_UNREACH;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (wr_en) begin
        left_dist <= eff;
        diag_dist <= up;
      end
    end
  end

  always_comb begin
    up = s1.first_row ? DIST_UNREACH : (fwd_hit ? fwd_data : rd_data);
    best = up;
    if (!s1.first_col && left_dist < best) begin
      best = left_dist;
    end
    if (!s1.first_row && !s1.first_col && diag_dist < best) begin
      best = diag_dist;
    end
    if (s1.first_row && s1.first_col) begin
      arrive = '0;
    end else if (best == DIST_UNREACH) begin
      arrive = DIST_UNREACH;
    end else if (best < DIST_SAT) begin
      arrive = best + 1'b1;
    end else begin
      arrive = DIST_SAT;
    end
    eff = s1.blocked ? DIST_UNREACH : arrive;
  end

  assign reachable     = (arrive != DIST_UNREACH);
  assign step_count    = reachable ? arrive[STEP_W-1:0] : '0;
  assign status.valid  = s1_valid;
  assign status.last   = s1.last;

endmodule

### sim/gmsp_path_checker.sv
// gmsp_path_checker: watches the apb, cell and result channels of grid_min_step_path,
// predicts the path result of every grid and compares it with the one the block returns
// depends on gmsp_pkg
module gmsp_path_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [gmsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          cell_valid,
  input  logic                          cell_stall,
  input  logic                          blocked,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic                          reachable,
  input  logic [gmsp_pkg::STEP_W-1:0]   step_count,
  output int                            mismatch_count,
  output int                            results_pending
);
  import gmsp_pkg::*;

  localparam logic [SIZE_W-1:0] RESET_ROWS = 9;
  localparam logic [SIZE_W-1:0] RESET_COLS = 5;
  localparam logic [DIST_W-1:0] NO_PATH    = '1;

  typedef struct packed {
    logic              reachable;
    logic [STEP_W-1:0] steps;
  } path_result_t;

  path_result_t      path_results_due[$];
  logic [DIST_W-1:0] prev_row_dist[MAX_COLS];
  logic [DIST_W-1:0] left_dist;
  logic [DIST_W-1:0] diag_dist;
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [SIZE_W-1:0] rows_cfg;
  logic [SIZE_W-1:0] cols_cfg;
  int                paths_seen;

  function automatic int unsigned dim_in_use(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic void restart_grid();
    cur_row   = 0;
    cur_col   = 0;
    left_dist = NO_PATH;
    diag_dist = NO_PATH;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("path %0d: %s", paths_seen, msg);
    mismatch_count++;
  endtask

  // one cell of the forward distance sweep
  task automatic advance_path(input logic cell_blocked);
    int unsigned       rows;
    int unsigned       cols;
    logic [DIST_W-1:0] up;
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] arrive;
    logic [DIST_W-1:0] eff;
    path_result_t      res;
    rows = dim_in_use(rows_cfg, MAX_ROWS);
    cols = dim_in_use(cols_cfg, MAX_COLS);
    if (cur_row >= rows || cur_col >= cols) restart_grid();
    up = (cur_row > 0) ? prev_row_dist[cur_col] : NO_PATH;
    if (cur_row == 0 && cur_col == 0) begin
      arrive = '0;
    end else begin
      best = NO_PATH;
      if (cur_col > 0 && left_dist < best) best = left_dist;
      if (up < best) best = up;
      if (cur_row > 0 && cur_col > 0 && diag_dist < best) best = diag_dist;
      if (best == NO_PATH) arrive = NO_PATH;
      else if (best < NO_PATH - 1'b1) arrive = best + 1'b1;
      else arrive = NO_PATH - 1'b1;
    end
    if (cur_row == rows - 1 && cur_col == cols - 1) begin
      // destination counts even when blocked
      res.reachable = (arrive != NO_PATH);
      res.steps     = res.reachable ? arrive[STEP_W-1:0] : '0;
      path_results_due.push_back(res);
      restart_grid();
    end else begin
      eff = cell_blocked ? NO_PATH : arrive;
      prev_row_dist[cur_col] = eff;
      diag_dist = up;
      left_dist = eff;
      if (cur_col + 1 >= cols) begin
        cur_col   = 0;
        cur_row   = cur_row + 1;
        left_dist = NO_PATH;
        diag_dist = NO_PATH;
      end else begin
        cur_col = cur_col + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    path_result_t due;
    if (rst) begin
      rows_cfg = RESET_ROWS;
      cols_cfg = RESET_COLS;
      restart_grid();
      path_results_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (path_results_due.size() == 0) begin
          report_mismatch($sformatf("result with none pending (reachable %0d steps %0d)",
                                    reachable, step_count));
        end else begin
          due = path_results_due.pop_front();
          if (reachable !== due.reachable)
            report_mismatch($sformatf("reachable expected %0d got %0d",
                                      due.reachable, reachable));
          if (step_count !== due.steps)
            report_mismatch($sformatf("step_count expected %0d got %0d",
                                      due.steps, step_count));
        end
        paths_seen++;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_COL_COUNT) cols_cfg = pwdata[SIZE_W-1:0];
        else rows_cfg = pwdata[SIZE_W-1:0];
        restart_grid();
      end
      if (cell_valid && !cell_stall) advance_path(blocked);
    end
    results_pending = path_results_due.size();
  end

endmodule

### sim/grid_min_step_path_tb.sv
// grid_min_step_path_tb: drives directed, corridor and random grids into grid_min_step_path
// with random idle and stall; gmsp_path_checker predicts and compares the results
// depends on gmsp_pkg, gmsp_path_checker and the rtl under rtl/core
module grid_min_step_path_tb;
  import gmsp_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int TOTAL_CELLS   = 1750;
  localparam int IDLE_PCT      = 29;

  typedef enum int {
    FILL_RANDOM,
    FILL_CORRIDOR,
    FILL_START_BLOCKED,
    FILL_END_BLOCKED,
    FILL_WALL
  } fill_e;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                cell_valid;
  logic                cell_stall;
  logic                blocked;
  logic                result_valid;
  logic                result_stall;
  logic                reachable;
  logic [STEP_W-1:0]   step_count;

  int                  mismatch_count;
  int                  results_pending;
  int                  cycle_count;
  int                  cells_sent;
  bit                  steady;
  bit                  hold_request;
  logic [SIZE_W-1:0]   rows_raw;
  logic [SIZE_W-1:0]   cols_raw;

  grid_min_step_path u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .blocked      (blocked),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .reachable    (reachable),
    .step_count   (step_count)
  );

  gmsp_path_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .cell_valid      (cell_valid),
    .cell_stall      (cell_stall),
    .blocked         (blocked),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .reachable       (reachable),
    .step_count      (step_count),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("grid_min_step_path_tb: errors");
    $finish;
  end

  // result side: random stall, a steady stretch, and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (steady) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  function automatic int dim_used(input logic [SIZE_W-1:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // mostly small sizes, now and then zero or beyond the maximum
  function automatic logic [SIZE_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 72) return SIZE_W'($urandom_range(1, 6));
    if (roll < 92) return SIZE_W'($urandom_range(7, 16));
    if (roll < 96) return '0;
    return SIZE_W'($urandom_range(17, 127));
  endfunction

  task automatic send_cell(input logic cell_blocked);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cell_valid <= 1'b0;
      @(negedge clk);
    end
    cell_valid <= 1'b1;
    blocked    <= cell_blocked;
    do @(posedge clk); while (cell_stall);
    cells_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    cell_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] value);
    logic [31:0] word;
    word = $urandom;
    word[SIZE_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] c);
    wait_idle();
    write_reg(REG_ROW_COUNT, r);
    write_reg(REG_COL_COUNT, c);
    rows_raw = r;
    cols_raw = c;
  endtask

  task automatic send_grid(input fill_e fill, input int pct);
    int   rows;
    int   cols;
    logic b;
    rows = dim_used(rows_raw, MAX_ROWS);
    cols = dim_used(cols_raw, MAX_COLS);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        case (fill)
          FILL_CORRIDOR:      b = !(r == 0 || c == cols - 1);
          FILL_START_BLOCKED: b = (r == 0 && c == 0);
          FILL_END_BLOCKED:   b = (r == rows - 1 && c == cols - 1);
          FILL_WALL:          b = (r == rows / 2);
          default:            b = ($urandom_range(99) < pct);
        endcase
        send_cell(b);
      end
    end
  endtask

  initial begin
    int                grid_no;
    int                span;
    int                pct;
    logic [SIZE_W-1:0] r;
    logic [SIZE_W-1:0] c;
    rst          = 1'b1;
    cell_valid   = 1'b0;
    blocked      = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rows_raw     = SIZE_W'(9);
    cols_raw     = SIZE_W'(5);
    steady       = 1'b0;
    hold_request = 1'b0;
    cells_sent   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // size left by reset, open grid
    send_grid(FILL_RANDOM, 0);
    // single cell is its own destination, blocked or not
    set_size(1, 1);
    send_grid(FILL_START_BLOCKED, 0);
    send_grid(FILL_RANDOM, 0);
    set_size(0, 0);
    send_grid(FILL_RANDOM, 50);
    set_size(3, 3);
    send_grid(FILL_START_BLOCKED, 0);
    send_grid(FILL_END_BLOCKED, 0);
    send_grid(FILL_WALL, 0);
    set_size(1, 4);
    send_grid(FILL_RANDOM, 0);
    set_size(4, 1);
    send_grid(FILL_RANDOM, 0);
    // a size write in the middle of a grid starts over
    set_size(2, 3);
    repeat (4) send_cell(1'($urandom_range(1)));
    set_size(2, 3);
    send_grid(FILL_RANDOM, 20);
    // long paths; the first of them pushes step_count into its top bit
    set_size(64, 3);
    send_grid(FILL_CORRIDOR, 0);
    set_size(2, 127);
    send_grid(FILL_CORRIDOR, 0);
    set_size(127, 1);
    send_grid(FILL_RANDOM, 0);

    grid_no = 0;
    while (cells_sent < TOTAL_CELLS) begin
      steady = (grid_no >= 25 && grid_no < 40);
      if (grid_no == 10) begin
        // tiny grids while results are held back, so the block backs up
        set_size(2, 2);
        hold_request = 1'b1;
      end else if ((grid_no < 10 || grid_no >= 20) && $urandom_range(99) < 40) begin
        r = pick_dim();
        c = pick_dim();
        if (dim_used(r, MAX_ROWS) > 16 && dim_used(c, MAX_COLS) > 4)
          c = SIZE_W'($urandom_range(1, 4));
        if (dim_used(c, MAX_COLS) > 16 && dim_used(r, MAX_ROWS) > 4)
          r = SIZE_W'($urandom_range(1, 4));
        set_size(r, c);
      end
      span = dim_used(rows_raw, MAX_ROWS) * dim_used(cols_raw, MAX_COLS);
      if (grid_no >= 20 && span > 1 && $urandom_range(99) < 5) begin
        // abandoned grid
        repeat ($urandom_range(1, span - 1)) send_cell(1'($urandom_range(1)));
        set_size(rows_raw, cols_raw);
      end else if ($urandom_range(99) < 5) begin
        send_grid(FILL_CORRIDOR, 0);
      end else begin
        case ($urandom_range(4))
          0:       pct = 0;
          1:       pct = 10;
          2:       pct = 25;
          3:       pct = 40;
          default: pct = 60;
        endcase
        send_grid(FILL_RANDOM, pct);
      end
      grid_no++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("grid_min_step_path_tb: clean");
    end else begin
      $display("grid_min_step_path_tb: errors");
    end
    $finish;
  end

endmodule
